// ----- sv/nfsa_pkg.sv -----
// shared types and constants for the neighbor force scatter accumulator
`timescale 1ns / 1ps

package nfsa_pkg;

    // field widths
    localparam int CENTER_W    = 12;
    localparam int NB_W        = 13;
    localparam int DATA_W      = 32;
    localparam int FORCE_W     = 64;
    localparam int IDX_W       = 17;
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 208;
    localparam int LANE_W      = 3 * FORCE_W;

    // operation codes carried on s_tuser
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_CUPD,
        ST_NRD,
        ST_NUPD,
        ST_RRD,
        ST_ROUT
    } state_t;

    // memory address source
    typedef enum logic [1:0] {
        ADDR_CENTER,
        ADDR_NEIGHBOR,
        ADDR_CLEAR
    } addr_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      capture;
        logic      rd_en;
        logic      wr_en;
        logic      wr_zero;
        logic      neg;
        logic      out_load;
        addr_sel_t addr_sel;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_op;
        logic center_ok;
        logic nb_ok;
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

// ----- sv/nfsa_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module nfsa_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/nfsa_ctrl.sv -----
// controller state machine sequencing memory reads and writes per beat
`timescale 1ns / 1ps

module nfsa_ctrl
    import nfsa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.wr_zero  = 1'b0;
        cmd.neg      = 1'b0;
        cmd.out_load = 1'b0;
        cmd.addr_sel = ADDR_CENTER;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_zero  = 1'b1;
                cmd.addr_sel = ADDR_CLEAR;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (status.in_op == OP_READ) ? ST_RRD : ST_MUL;
                end
            end
            ST_MUL:
            begin
                // products register while the center entry is fetched
                cmd.rd_en  = 1'b1;
                state_next = ST_CUPD;
            end
            ST_CUPD:
            begin
                cmd.wr_en  = status.center_ok;
                cmd.neg    = 1'b1;
                state_next = status.nb_ok ? ST_NRD : ST_IDLE;
            end
            ST_NRD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_NEIGHBOR;
                state_next   = ST_NUPD;
            end
            ST_NUPD:
            begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = ADDR_NEIGHBOR;
                state_next   = ST_IDLE;
            end
            ST_RRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_ROUT;
            end
            ST_ROUT:
            begin
                // wait for the output register, then clear the entry
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.wr_en    = status.center_ok;
                    cmd.wr_zero  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/nfsa_dp.sv -----
// datapath: input capture, products, saturating update, force memory, output register
`timescale 1ns / 1ps

module nfsa_dp
    import nfsa_pkg::*;
#(
    parameter int ATOMS = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(ATOMS);

    logic [CENTER_W-1:0]      center_reg;
    logic [NB_W-1:0]          nb_reg;
    logic signed [DATA_W-1:0] nd_reg;
    logic signed [DATA_W-1:0] dx_reg;
    logic signed [DATA_W-1:0] dy_reg;
    logic signed [DATA_W-1:0] dz_reg;

    logic signed [FORCE_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [FORCE_W-1:0] px_next, py_next, pz_next;

    logic [AW-1:0]          clear_cnt_reg;
    logic [AW-1:0]          clear_cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CENTER_W-1:0]    out_atom_reg;
    logic [LANE_W-1:0]      out_force_reg;

    logic [IDX_W-1:0]       center_ext;
    logic [IDX_W-1:0]       nb_ext;
    logic                   center_ok;
    logic [AW-1:0]          addr;
    logic [LANE_W-1:0]      rd_data;
    logic [LANE_W-1:0]      wr_data;
    logic signed [FORCE_W-1:0] sx, sy, sz;

    function automatic logic signed [FORCE_W-1:0] sat_add(
        input logic signed [FORCE_W-1:0] a,
        input logic signed [FORCE_W-1:0] b
    );
        logic signed [FORCE_W:0] s;
        s = {a[FORCE_W-1], a} + {b[FORCE_W-1], b};
        if (s[FORCE_W] != s[FORCE_W-1])
        begin
            sat_add = s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}}
                                 : {1'b0, {(FORCE_W-1){1'b1}}};
        end
        else
        begin
            sat_add = s[FORCE_W-1:0];
        end
    endfunction

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            center_reg <= s_tdata[11:0];
            nb_reg     <= s_tdata[24:12];
            nd_reg     <= s_tdata[56:25];
            dx_reg     <= s_tdata[88:57];
            dy_reg     <= s_tdata[120:89];
            dz_reg     <= s_tdata[152:121];
        end
    end

    // one multiplier per component, registered
    always_comb
    begin
        px_next = nd_reg * dx_reg;
        py_next = nd_reg * dy_reg;
        pz_next = nd_reg * dz_reg;
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        pz_reg <= pz_next;
    end

    // range checks and address select
    assign center_ext = IDX_W'(center_reg);
    assign nb_ext     = IDX_W'(nb_reg[NB_W-2:0]);
    assign center_ok  = center_ext < IDX_W'(ATOMS);

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_NEIGHBOR: addr = nb_ext[AW-1:0];
            ADDR_CLEAR:    addr = clear_cnt_reg;
            default:       addr = center_ext[AW-1:0];
        endcase
    end

    // saturating update, product subtracted for the center and added for the neighbor
    always_comb
    begin
        sx = sat_add(rd_data[FORCE_W-1:0],           cmd.neg ? -px_reg : px_reg);
        sy = sat_add(rd_data[2*FORCE_W-1:FORCE_W],   cmd.neg ? -py_reg : py_reg);
        sz = sat_add(rd_data[3*FORCE_W-1:2*FORCE_W], cmd.neg ? -pz_reg : pz_reg);
        wr_data = cmd.wr_zero ? '0 : {sz, sy, sx};
    end

    // force store, x, y and z side by side
    nfsa_ram #(
        .WIDTH (LANE_W),
        .DEPTH (ATOMS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // clearing pass counter
    always_comb
    begin
        clear_cnt_next = clear_cnt_reg;
        if (cmd.wr_en && cmd.addr_sel == ADDR_CLEAR)
        begin
            clear_cnt_next = status.clear_last ? '0 : clear_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_atom_reg  <= center_reg;
            out_force_reg <= center_ok ? rd_data : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_force_reg, out_atom_reg};

    // status back to the controller
    always_comb
    begin
        status.in_op      = s_tuser;
        status.center_ok  = center_ok;
        status.nb_ok      = !nb_reg[NB_W-1] && (nb_ext < IDX_W'(ATOMS));
        status.clear_last = clear_cnt_reg == AW'(ATOMS - 1);
        status.out_free   = !out_valid_reg || m_tready;
    end

endmodule

// ----- sv/neighbor_force_scatter_accumulate.sv -----
// top level of the neighbor force scatter accumulator
`timescale 1ns / 1ps

// Keeps a saturating Q32.32 force vector per atom in one memory and takes one
// beat at a time. An accumulate beat passes through ST_MUL and ST_CUPD, then
// ST_NRD and ST_NUPD unless the neighbor is empty or out of range: the
// products are registered while the center entry is read, then each touched
// entry gets a read and a write-back on the memory's single read and single
// write port. A read beat passes through ST_RRD and ST_ROUT, where it waits for
// the output register; it returns the atom's force and writes zero back. After
// reset a clearing pass writes zero to all ATOMS entries, one per cycle, and no
// beat is accepted until it ends.
module neighbor_force_scatter_accumulate
    import nfsa_pkg::*;
#(
    parameter int ATOMS = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // center_atom, neighbor_atom, net_grad, deriv_x, deriv_y, deriv_z, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // atom, force_x, force_y, force_z, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t status;

    // controller
    nfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    nfsa_dp #(
        .ATOMS (ATOMS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // memory writes never overlap beat acceptance
    assert property (@(posedge clk) disable iff (!rst_n) cmd.wr_en |-> !s_tready)
        else $error("memory write while accepting a beat");

    // read and write-back never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n) cmd.rd_en |-> !cmd.wr_en)
        else $error("memory read and write in the same cycle");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n) cmd.out_load |-> status.out_free)
        else $error("output register loaded while full");

    // a result appears only after an output load
    assert property (@(posedge clk) disable iff (!rst_n) $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result shown without a load");

endmodule

// ----- sim/tb_neighbor_force_scatter_accumulate.sv -----
// testbench for the neighbor force scatter accumulator with its own force predictor
`timescale 1ns / 1ps

module tb_neighbor_force_scatter_accumulate;
    import nfsa_pkg::*;

    localparam int ATOMS_N     = 4096;
    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 20;

    // handy q16.16 values
    localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_MAXV = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MINV = 32'sh8000_0000;
    localparam logic signed [NB_W-1:0]   NB_EMPTY = -13'sd1;
    localparam logic signed [NB_W-1:0]   NB_MOST_NEG = 13'sh1000;

    typedef struct packed {
        logic [CENTER_W-1:0]       atom;
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
        logic signed [FORCE_W-1:0] fz;
    } force_readout_t;

    // per-atom force store and the queue of readouts still owed by the block
    class force_scoreboard;
        logic signed [FORCE_W-1:0] acc_x [ATOMS_N];
        logic signed [FORCE_W-1:0] acc_y [ATOMS_N];
        logic signed [FORCE_W-1:0] acc_z [ATOMS_N];
        force_readout_t            owed_reads [$];
        int unsigned               errors;

        function new();
            for (int i = 0; i < ATOMS_N; i++)
            begin
                acc_x[i] = '0;
                acc_y[i] = '0;
                acc_z[i] = '0;
            end
            errors = 0;
        endfunction

        // signed 64-bit add clamped to the representable range
        function logic signed [FORCE_W-1:0] sat_sum(input logic signed [FORCE_W-1:0] a,
                                                    input logic signed [FORCE_W-1:0] b);
            logic signed [FORCE_W:0] s;
            s = {a[FORCE_W-1], a} + {b[FORCE_W-1], b};
            if (s[FORCE_W] != s[FORCE_W-1])
                return s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
            return s[FORCE_W-1:0];
        endfunction

        function int pending();
            return owed_reads.size();
        endfunction

        // update the store for one accepted input beat
        function void note_beat(input logic op, input logic [CENTER_W-1:0] center,
                                input logic signed [NB_W-1:0] nb,
                                input logic signed [DATA_W-1:0] nd,
                                input logic signed [DATA_W-1:0] dx,
                                input logic signed [DATA_W-1:0] dy,
                                input logic signed [DATA_W-1:0] dz);
            force_readout_t r;
            longint px;
            longint py;
            longint pz;
            int ci;
            int ni;
            ci = int'(center);
            ni = int'(nb);
            if (op == OP_READ)
            begin
                r.atom = center;
                if (ci < ATOMS_N)
                begin
                    r.fx = acc_x[ci];
                    r.fy = acc_y[ci];
                    r.fz = acc_z[ci];
                    acc_x[ci] = '0;
                    acc_y[ci] = '0;
                    acc_z[ci] = '0;
                end
                else
                begin
                    r.fx = '0;
                    r.fy = '0;
                    r.fz = '0;
                end
                owed_reads.push_back(r);
                return;
            end
            // exact q32.32 products, magnitude at most 2^62
            px = longint'(nd) * longint'(dx);
            py = longint'(nd) * longint'(dy);
            pz = longint'(nd) * longint'(dz);
            // center first, then neighbor (order matters when both are the same atom)
            if (ci < ATOMS_N)
            begin
                acc_x[ci] = sat_sum(acc_x[ci], -px);
                acc_y[ci] = sat_sum(acc_y[ci], -py);
                acc_z[ci] = sat_sum(acc_z[ci], -pz);
            end
            if (ni >= 0 && ni < ATOMS_N)
            begin
                acc_x[ni] = sat_sum(acc_x[ni], px);
                acc_y[ni] = sat_sum(acc_y[ni], py);
                acc_z[ni] = sat_sum(acc_z[ni], pz);
            end
        endfunction

        // compare one output beat with the oldest owed readout
        function void check_readout(input logic [OUT_TDATA_W-1:0] beat);
            force_readout_t got;
            force_readout_t want;
            got.atom = beat[CENTER_W-1:0];
            got.fx   = beat[CENTER_W +: FORCE_W];
            got.fy   = beat[CENTER_W+FORCE_W +: FORCE_W];
            got.fz   = beat[CENTER_W+2*FORCE_W +: FORCE_W];
            if (owed_reads.size() == 0)
            begin
                $error("unexpected output beat: atom %0d", got.atom);
                errors++;
                return;
            end
            want = owed_reads.pop_front();
            if (got.atom !== want.atom)
            begin
                $error("atom mismatch: expected %0d, actual %0d", want.atom, got.atom);
                errors++;
            end
            if (got.fx !== want.fx)
            begin
                $error("force_x mismatch: expected %0d, actual %0d", want.fx, got.fx);
                errors++;
            end
            if (got.fy !== want.fy)
            begin
                $error("force_y mismatch: expected %0d, actual %0d", want.fy, got.fy);
                errors++;
            end
            if (got.fz !== want.fz)
            begin
                $error("force_z mismatch: expected %0d, actual %0d", want.fz, got.fz);
                errors++;
            end
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    force_scoreboard        sb;
    int unsigned            cycle_count = 0;
    logic [CENTER_W-1:0]    hot_atoms [6] = '{12'd0, 12'd1, 12'd2047, 12'd2048, 12'd4094,
                                              12'd4095};

    neighbor_force_scatter_accumulate #(
        .ATOMS(ATOMS_N)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: check accepted beats, stall in changing modes
    int unsigned rdy_mode = 0;
    int unsigned rdy_left = 0;
    int unsigned rdy_phase = 0;

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_readout(m_tdata);
        rdy_phase <= rdy_phase + 1;
        if (rdy_left == 0)
        begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_left <= $urandom_range(40, 300);
        end
        else
            rdy_left <= rdy_left - 1;
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 99) < 60);
            2: m_tready <= (rdy_phase % 5 == 0);
            default: m_tready <= (rdy_phase % 16 == 0);
        endcase
    end

    // present one beat and hold it until accepted; valid stays high afterwards
    task automatic send_beat(input logic op, input logic [CENTER_W-1:0] center,
                             input logic signed [NB_W-1:0] nb,
                             input logic signed [DATA_W-1:0] nd,
                             input logic signed [DATA_W-1:0] dx,
                             input logic signed [DATA_W-1:0] dy,
                             input logic signed [DATA_W-1:0] dz);
        s_tuser  <= op;
        s_tdata  <= {7'b0, dz, dy, dx, nd, nb, center};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(op, center, nb, nd, dx, dy, dz);
    endtask

    task automatic read_atom(input logic [CENTER_W-1:0] atom);
        send_beat(OP_READ, atom, $signed(13'($urandom)), $urandom, $urandom, $urandom,
                  $urandom);
    endtask

    task automatic idle_gap(input int unsigned n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold off until every owed readout has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // q16.16 value with a mix of magnitudes and corner values
    function automatic logic signed [DATA_W-1:0] rand_q16();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k <= 3)
            return $urandom;
        if (k <= 6)
            return DATA_W'(int'($urandom_range(0, 262143)) - 131072);
        if (k == 7)
        begin
            case ($urandom_range(0, 3))
                0: return Q_MINV;
                1: return Q_MAXV;
                2: return -32'sd1;
                default: return '0;
            endcase
        end
        if (k == 8)
            return ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) <<< $urandom_range(0, 30);
        return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
    endfunction

    function automatic logic [CENTER_W-1:0] rand_atom();
        if ($urandom_range(0, 99) < 70)
            return hot_atoms[$urandom_range(0, 5)];
        return CENTER_W'($urandom_range(0, ATOMS_N - 1));
    endfunction

    // one random beat: mostly accumulates on a few hot atoms, some reads
    task automatic send_random();
        logic [CENTER_W-1:0]     center;
        logic signed [NB_W-1:0]  nb;
        int unsigned             r;
        center = rand_atom();
        if ($urandom_range(0, 99) < 14)
        begin
            read_atom(center);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            nb = NB_W'(-int'($urandom_range(1, 4096)));
        else if (r < 22)
            nb = $signed({1'b0, center});
        else
            nb = $signed({1'b0, rand_atom()});
        send_beat(OP_ACCUM, center, nb, rand_q16(), rand_q16(), rand_q16(), rand_q16());
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        bit          drained_mid;
        sb = new();
        sent = 0;
        drained_mid = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fresh read, empty slots, neighbor, same atom
        read_atom(12'd5);
        send_beat(OP_ACCUM, 12'd5, NB_EMPTY, Q_ONE, 32'sh0002_0000, -32'sh0003_0000, Q_MAXV);
        send_beat(OP_ACCUM, 12'd5, NB_MOST_NEG, Q_MAXV, Q_MINV, -32'sd1, 32'sd1);
        send_beat(OP_ACCUM, 12'd6, 13'sd5, -Q_ONE, 32'sh0000_8000, Q_MAXV, Q_MINV);
        send_beat(OP_ACCUM, 12'd7, 13'sd7, Q_MINV, Q_MINV, Q_MAXV, 32'sh0001_8000);
        // drive one pair into both saturation limits, then back out
        send_beat(OP_ACCUM, 12'd10, 13'sd11, Q_MINV, Q_MINV, Q_MINV, Q_MAXV);
        send_beat(OP_ACCUM, 12'd10, 13'sd11, Q_MINV, Q_MINV, Q_MINV, Q_MAXV);
        send_beat(OP_ACCUM, 12'd10, 13'sd11, Q_MINV, Q_MINV, Q_MINV, Q_MAXV);
        send_beat(OP_ACCUM, 12'd10, 13'sd11, Q_MINV, Q_MINV, Q_MINV, Q_MAXV);
        send_beat(OP_ACCUM, 12'd11, 13'sd10, Q_MAXV, Q_MAXV, -Q_ONE, Q_ONE);
        // extreme atom numbers
        send_beat(OP_ACCUM, 12'd4095, 13'sd4095, Q_MAXV, Q_MAXV, Q_MAXV, Q_MAXV);
        send_beat(OP_ACCUM, 12'd0, 13'sd4095, Q_MAXV, Q_MINV, '0, -32'sd1);
        send_beat(OP_ACCUM, 12'd0, 13'sd0, '0, Q_MINV, Q_MAXV, Q_ONE);
        read_atom(12'd5);
        read_atom(12'd6);
        read_atom(12'd7);
        read_atom(12'd10);
        read_atom(12'd11);
        read_atom(12'd4095);
        read_atom(12'd0);
        // cleared entry reads back zero
        read_atom(12'd5);
        wait_for_drain();

        // random bursts with gaps and occasional full drains
        while (sent < ITEM_TARGET)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst; i++)
                send_random();
            sent += burst;
            if (!drained_mid && sent >= ITEM_TARGET / 2)
            begin
                drained_mid = 1'b1;
                wait_for_drain();
            end
            else if ($urandom_range(0, 9) == 0)
                wait_for_drain();
            else if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 8));
        end

        // sweep the hot atoms so leftover sums are checked
        for (int i = 0; i < 6; i++)
            read_atom(hot_atoms[i]);
        wait_for_drain();
        repeat (SETTLE_CYC) @(posedge clk);

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
